// ===== src/led_pkg.sv =====
// Shared constants for the line editor: field widths and key symbol codes.
package led_pkg;

    localparam int KEY_W  = 16;
    localparam int CHAR_W = 7;
    localparam int POS_W  = 6;

    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 16'h0008;
    localparam logic [KEY_W-1:0] KEY_ENTER     = 16'h000D;
    localparam logic [KEY_W-1:0] KEY_LEFT      = 16'h0101;
    localparam logic [KEY_W-1:0] KEY_RIGHT     = 16'h0102;
    localparam logic [KEY_W-1:0] KEY_UP        = 16'h0103;
    localparam logic [KEY_W-1:0] KEY_DOWN      = 16'h0104;
    localparam logic [KEY_W-1:0] KEY_HOME      = 16'h0105;
    localparam logic [KEY_W-1:0] KEY_END       = 16'h0106;
    localparam logic [KEY_W-1:0] KEY_DELETE    = 16'h0107;
    localparam logic [KEY_W-1:0] KEY_CLEAR     = 16'h206C;

    localparam logic [KEY_W-1:0] PRINT_LO = 16'd32;
    localparam logic [KEY_W-1:0] PRINT_HI = 16'd127;

    localparam logic [POS_W-1:0] VIEW_WIDTH_RST = 6'd30;

    typedef logic [POS_W-1:0] pos_t;

endpackage

// ===== src/led_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module led_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/line_editor_with_history_unit.sv =====
// Line editor top level: key decode, sequencer, line and history memories.
//
// Takes one key symbol per beat and answers with zero or more character beats
// (Enter only) followed by one status beat marked last. The block accepts a
// key only when the sequencer is idle. Insert and delete shift each character,
// recall copies each history character and Enter sends each character, which
// can stall on the output, because every character is moved as a RAM read
// followed by a write. No clearing pass is needed after reset.
module line_editor_with_history_unit #(
    parameter int MAX_LEN  = 63,
    parameter int HIST_LEN = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_key_symbol,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [6:0]  m_line_char,
    output logic [5:0]  m_cursor_pos,
    output logic [5:0]  m_line_length,
    output logic [5:0]  m_view_start,
    output logic        m_last
);

    localparam int LW  = $clog2(MAX_LEN);
    localparam int SW  = $clog2(HIST_LEN);
    localparam int HD  = HIST_LEN * MAX_LEN;
    localparam int HAW = $clog2(HD);
    localparam int PW  = led_pkg::POS_W;
    localparam int CW  = led_pkg::CHAR_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RM_RD  = 4'd1;
    localparam logic [3:0] ST_RM_WR  = 4'd2;
    localparam logic [3:0] ST_INS_RD = 4'd3;
    localparam logic [3:0] ST_INS_WR = 4'd4;
    localparam logic [3:0] ST_RC_RD  = 4'd5;
    localparam logic [3:0] ST_RC_WR  = 4'd6;
    localparam logic [3:0] ST_EN_RD  = 4'd7;
    localparam logic [3:0] ST_EN_WR  = 4'd8;
    localparam logic [3:0] ST_STAT   = 4'd9;

    localparam logic [SW-1:0] SLOT_LAST = SW'(HIST_LEN - 1);
    localparam logic [PW-1:0] LEN_MAX   = PW'(MAX_LEN);

    logic [3:0]     state_reg, state_next;
    led_pkg::pos_t  cur_reg, cur_next;
    led_pkg::pos_t  len_reg, len_next;
    led_pkg::pos_t  ws_reg, ws_next;
    led_pkg::pos_t  vw_reg;
    led_pkg::pos_t  idx_reg, idx_next;
    led_pkg::pos_t  lim_reg, lim_next;
    logic [CW-1:0]  key_reg, key_next;
    logic           fix_reg, fix_next;
    logic [SW-1:0]  hslot_reg, hslot_next;
    logic [SW-1:0]  wslot_reg, wslot_next;
    logic [SW-1:0]  rslot_reg, rslot_next;
    led_pkg::pos_t  hlen_reg [HIST_LEN];

    logic           hlen_we;
    logic [SW-1:0]  hlen_waddr;
    led_pkg::pos_t  hlen_wdata;

    logic           m_valid_reg, m_valid_next;
    logic           m_kind_reg, m_kind_next;
    logic [CW-1:0]  m_char_reg, m_char_next;
    led_pkg::pos_t  m_cur_reg, m_cur_next;
    led_pkg::pos_t  m_len_reg, m_len_next;
    led_pkg::pos_t  m_ws_reg, m_ws_next;
    logic           m_last_reg, m_last_next;

    logic           lb_we, lb_re;
    logic [LW-1:0]  lb_waddr, lb_raddr;
    logic [CW-1:0]  lb_wdata, lb_rdata;
    logic           hr_we, hr_re;
    logic [HAW-1:0] hr_addr;
    logic [CW-1:0]  hr_rdata;

    logic           out_free;
    logic [SW-1:0]  up_slot, dn_slot;
    led_pkg::pos_t  idx_inc, idx_dec, ws_fix;
    logic [PW:0]    idx_inc_w;

    // Line buffer and history row storage
    led_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_line_ram (
        .aclk  (aclk),
        .we    (lb_we),
        .waddr (lb_waddr),
        .wdata (lb_wdata),
        .re    (lb_re),
        .raddr (lb_raddr),
        .rdata (lb_rdata)
    );

    led_ram #(.WIDTH(CW), .DEPTH(HD)) u_hist_ram (
        .aclk  (aclk),
        .we    (hr_we),
        .waddr (hr_addr),
        .wdata (lb_rdata),
        .re    (hr_re),
        .raddr (hr_addr),
        .rdata (hr_rdata)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_line_char   = m_char_reg;
    assign m_cursor_pos  = m_cur_reg;
    assign m_line_length = m_len_reg;
    assign m_view_start  = m_ws_reg;
    assign m_last        = m_last_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign idx_inc_w = {1'b0, idx_reg} + 7'd1;
    assign idx_inc   = idx_inc_w[PW-1:0];
    assign idx_dec   = idx_reg - 6'd1;
    assign up_slot   = (rslot_reg == '0) ? SLOT_LAST : rslot_reg - SW'(1);
    assign dn_slot   = (rslot_reg >= SLOT_LAST) ? '0 : rslot_reg + SW'(1);
    assign hr_addr   = HAW'(hslot_reg) * HAW'(MAX_LEN) + HAW'(idx_reg);

    // View correction on the committed cursor
    always_comb begin
        ws_fix = ws_reg;
        if (cur_reg < ws_reg) begin
            ws_fix = cur_reg;
        end else if (cur_reg - ws_reg > vw_reg) begin
            ws_fix = cur_reg - vw_reg;
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        len_next     = len_reg;
        ws_next      = ws_reg;
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        key_next     = key_reg;
        fix_next     = fix_reg;
        hslot_next   = hslot_reg;
        wslot_next   = wslot_reg;
        rslot_next   = rslot_reg;
        hlen_we      = 1'b0;
        hlen_waddr   = wslot_reg;
        hlen_wdata   = len_reg;
        lb_we        = 1'b0;
        lb_waddr     = idx_reg[LW-1:0];
        lb_wdata     = hr_rdata;
        lb_re        = 1'b0;
        lb_raddr     = idx_reg[LW-1:0];
        hr_we        = 1'b0;
        hr_re        = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_char_next  = m_char_reg;
        m_cur_next   = m_cur_reg;
        m_len_next   = m_len_reg;
        m_ws_next    = m_ws_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    fix_next   = 1'b0;
                    state_next = ST_STAT;
                    key_next   = s_key_symbol[CW-1:0];
                    unique case (s_key_symbol)
                        led_pkg::KEY_BACKSPACE: begin
                            if (cur_reg != '0) begin
                                idx_next   = cur_reg - 6'd1;
                                lim_next   = len_reg;
                                cur_next   = cur_reg - 6'd1;
                                len_next   = len_reg - 6'd1;
                                fix_next   = 1'b1;
                                state_next = ST_RM_RD;
                            end
                        end
                        led_pkg::KEY_DELETE: begin
                            if (cur_reg < len_reg) begin
                                idx_next   = cur_reg;
                                lim_next   = len_reg;
                                len_next   = len_reg - 6'd1;
                                state_next = ST_RM_RD;
                            end
                        end
                        led_pkg::KEY_LEFT: begin
                            if (cur_reg != '0) begin
                                cur_next = cur_reg - 6'd1;
                                fix_next = 1'b1;
                            end
                        end
                        led_pkg::KEY_RIGHT: begin
                            if (cur_reg < len_reg) begin
                                cur_next = cur_reg + 6'd1;
                                fix_next = 1'b1;
                            end
                        end
                        led_pkg::KEY_HOME: begin
                            cur_next = '0;
                            fix_next = 1'b1;
                        end
                        led_pkg::KEY_END: begin
                            cur_next = len_reg;
                            fix_next = 1'b1;
                        end
                        led_pkg::KEY_CLEAR: begin
                            cur_next = '0;
                            len_next = '0;
                            fix_next = 1'b1;
                        end
                        led_pkg::KEY_UP, led_pkg::KEY_DOWN: begin
                            hslot_next = (s_key_symbol == led_pkg::KEY_UP) ? up_slot : dn_slot;
                            if (hlen_reg[hslot_next] != '0) begin
                                rslot_next = hslot_next;
                                len_next   = hlen_reg[hslot_next];
                                cur_next   = hlen_reg[hslot_next];
                                lim_next   = hlen_reg[hslot_next];
                                ws_next    = '0;
                                idx_next   = '0;
                                fix_next   = 1'b1;
                                state_next = ST_RC_RD;
                            end
                        end
                        led_pkg::KEY_ENTER: begin
                            if (len_reg != '0) begin
                                hlen_we    = 1'b1;
                                hslot_next = wslot_reg;
                                wslot_next = (wslot_reg >= SLOT_LAST) ? '0 : wslot_reg + SW'(1);
                                rslot_next = wslot_next;
                                lim_next   = len_reg;
                                idx_next   = '0;
                                cur_next   = '0;
                                len_next   = '0;
                                fix_next   = 1'b1;
                                state_next = ST_EN_RD;
                            end
                        end
                        default: begin
                            if (len_reg < LEN_MAX && s_key_symbol >= led_pkg::PRINT_LO
                                    && s_key_symbol <= led_pkg::PRINT_HI) begin
                                idx_next   = len_reg;
                                lim_next   = cur_reg;
                                len_next   = len_reg + 6'd1;
                                cur_next   = cur_reg + 6'd1;
                                fix_next   = 1'b1;
                                state_next = ST_INS_RD;
                            end
                        end
                    endcase
                end
            end
            // close the gap: buf[n] = buf[n+1]
            ST_RM_RD: begin
                if (idx_inc_w < {1'b0, lim_reg}) begin
                    lb_re      = 1'b1;
                    lb_raddr   = idx_inc[LW-1:0];
                    state_next = ST_RM_WR;
                end else begin
                    state_next = ST_STAT;
                end
            end
            ST_RM_WR: begin
                lb_we      = 1'b1;
                lb_wdata   = lb_rdata;
                idx_next   = idx_inc;
                state_next = ST_RM_RD;
            end
            // open a gap: buf[n] = buf[n-1], then drop the key in
            ST_INS_RD: begin
                if (idx_reg > lim_reg) begin
                    lb_re      = 1'b1;
                    lb_raddr   = idx_dec[LW-1:0];
                    state_next = ST_INS_WR;
                end else begin
                    lb_we      = 1'b1;
                    lb_waddr   = lim_reg[LW-1:0];
                    lb_wdata   = key_reg;
                    state_next = ST_STAT;
                end
            end
            ST_INS_WR: begin
                lb_we      = 1'b1;
                lb_wdata   = lb_rdata;
                idx_next   = idx_dec;
                state_next = ST_INS_RD;
            end
            // history row into the line buffer
            ST_RC_RD: begin
                if (idx_reg < lim_reg) begin
                    hr_re      = 1'b1;
                    state_next = ST_RC_WR;
                end else begin
                    state_next = ST_STAT;
                end
            end
            ST_RC_WR: begin
                lb_we      = 1'b1;
                lb_wdata   = hr_rdata;
                idx_next   = idx_inc;
                state_next = ST_RC_RD;
            end
            // save and emit the entered line
            ST_EN_RD: begin
                if (idx_reg < lim_reg) begin
                    lb_re      = 1'b1;
                    state_next = ST_EN_WR;
                end else begin
                    state_next = ST_STAT;
                end
            end
            ST_EN_WR: begin
                if (out_free) begin
                    hr_we        = 1'b1;
                    m_valid_next = 1'b1;
                    m_kind_next  = 1'b1;
                    m_char_next  = lb_rdata;
                    m_cur_next   = '0;
                    m_len_next   = '0;
                    m_ws_next    = '0;
                    m_last_next  = 1'b0;
                    idx_next     = idx_inc;
                    state_next   = ST_EN_RD;
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    ws_next      = fix_reg ? ws_fix : ws_reg;
                    m_valid_next = 1'b1;
                    m_kind_next  = 1'b0;
                    m_char_next  = '0;
                    m_cur_next   = cur_reg;
                    m_len_next   = len_reg;
                    m_ws_next    = ws_next;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            len_reg     <= '0;
            ws_reg      <= '0;
            vw_reg      <= led_pkg::VIEW_WIDTH_RST;
            fix_reg     <= 1'b0;
            wslot_reg   <= '0;
            rslot_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < HIST_LEN; i++) begin
                hlen_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            len_reg     <= len_next;
            ws_reg      <= ws_next;
            fix_reg     <= fix_next;
            wslot_reg   <= wslot_next;
            rslot_reg   <= rslot_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                vw_reg <= cfg_wr_data;
            end
            if (hlen_we) begin
                hlen_reg[hlen_waddr] <= hlen_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        lim_reg    <= lim_next;
        key_reg    <= key_next;
        hslot_reg  <= hslot_next;
        m_kind_reg <= m_kind_next;
        m_char_reg <= m_char_next;
        m_cur_reg  <= m_cur_next;
        m_len_reg  <= m_len_next;
        m_ws_reg   <= m_ws_next;
        m_last_reg <= m_last_next;
    end

endmodule

// ===== src/led_chk.sv =====
// Port-level checks for the line editor, bound to the top level.
module led_chk #(
    parameter int MAX_LEN = 63
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [5:0]  m_cursor_pos,
    input logic [5:0]  m_line_length,
    input logic        m_last
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before accept");

    // only the status beat closes a key
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == !m_kind))
        else $error("last mark disagrees with beat kind");

    // status never shows a cursor past the line or a line past capacity
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> (m_cursor_pos <= m_line_length)
            && (m_line_length <= 6'(MAX_LEN)))
        else $error("status cursor or length out of range");

    // one key at a time: busy right after a key is taken
    a_busy_after_key: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second key taken while busy");

endmodule

bind line_editor_with_history_unit led_chk #(.MAX_LEN(MAX_LEN)) u_led_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_cursor_pos  (m_cursor_pos),
    .m_line_length (m_line_length),
    .m_last        (m_last)
);

// ===== sim/testbench.sv =====
// Testbench for the line editor: key beats in, status and line beats checked.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN  = 63;
    localparam int HIST_LEN = 8;

    typedef struct packed {
        logic       kind;
        logic [6:0] ch;
        logic [5:0] cur;
        logic [5:0] len;
        logic [5:0] vs;
        logic       last;
    } edit_beat_t;

    // Line editor behavior and the queue of beats it should produce
    class edit_scoreboard;
        logic [5:0] view_w;
        logic [6:0] line [MAX_LEN];
        int         cur, len, vs;
        logic [6:0] hist [HIST_LEN][MAX_LEN];
        int         hist_len [HIST_LEN];
        int         wr_slot, rc_slot;
        edit_beat_t pending[$];
        int         errors, checked, keys, lines;

        function new();
            view_w = led_pkg::VIEW_WIDTH_RST;
            cur = 0; len = 0; vs = 0; wr_slot = 0; rc_slot = 0;
            errors = 0; checked = 0; keys = 0; lines = 0;
            foreach (hist_len[i]) hist_len[i] = 0;
        endfunction

        function void fix_view();
            if (cur < vs) vs = cur;
            else if (cur - vs > view_w) vs = cur - view_w;
        endfunction

        function void drop_char(int pos);
            for (int n = pos; n + 1 < len; n++) line[n] = line[n + 1];
        endfunction

        function void load_row(int slot);
            rc_slot = slot;
            len = hist_len[slot];
            for (int i = 0; i < len; i++) line[i] = hist[slot][i];
            cur = len;
            vs = 0;
            fix_view();
        endfunction

        // Note an accepted key and queue the beats it causes
        function void note_key(logic [15:0] k);
            edit_beat_t b;
            int s;
            keys++;
            case (k)
                led_pkg::KEY_BACKSPACE: if (cur > 0) begin
                    drop_char(cur - 1); cur--; len--; fix_view();
                end
                led_pkg::KEY_DELETE: if (cur < len) begin
                    drop_char(cur); len--;
                end
                led_pkg::KEY_LEFT: if (cur > 0) begin
                    cur--; fix_view();
                end
                led_pkg::KEY_HOME: begin
                    cur = 0; fix_view();
                end
                led_pkg::KEY_END: begin
                    cur = len; fix_view();
                end
                led_pkg::KEY_RIGHT: if (cur < len) begin
                    cur++; fix_view();
                end
                led_pkg::KEY_CLEAR: begin
                    cur = 0; len = 0; fix_view();
                end
                led_pkg::KEY_UP: begin
                    s = (rc_slot > 0) ? rc_slot - 1 : HIST_LEN - 1;
                    if (hist_len[s] > 0) load_row(s);
                end
                led_pkg::KEY_DOWN: begin
                    s = (rc_slot >= HIST_LEN - 1) ? 0 : rc_slot + 1;
                    if (hist_len[s] > 0) load_row(s);
                end
                led_pkg::KEY_ENTER: if (len > 0) begin
                    for (int i = 0; i < len; i++) hist[wr_slot][i] = line[i];
                    hist_len[wr_slot] = len;
                    wr_slot = (wr_slot + 1) % HIST_LEN;
                    rc_slot = wr_slot;
                    lines++;
                    for (int i = 0; i < len; i++) begin
                        b = '0; b.kind = 1'b1; b.ch = line[i];
                        pending.push_back(b);
                    end
                    cur = 0; len = 0; fix_view();
                end
                default: if (len < MAX_LEN && k >= led_pkg::PRINT_LO
                             && k <= led_pkg::PRINT_HI) begin
                    for (int n = len; n > cur; n--) line[n] = line[n - 1];
                    line[cur] = k[6:0];
                    len++; cur++; fix_view();
                end
            endcase
            b = '0;
            b.cur = cur[5:0]; b.len = len[5:0]; b.vs = vs[5:0]; b.last = 1'b1;
            pending.push_back(b);
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_beat(edit_beat_t got);
            edit_beat_t exp_b;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %p", got);
                return;
            end
            exp_b = pending.pop_front();
            if (got !== exp_b) begin
                errors++;
                if (errors <= 10)
                    $display("beat %0d mismatch: exp %p got %p", checked, exp_b, got);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_key_symbol = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [6:0]  m_line_char;
    logic [5:0]  m_cursor_pos, m_line_length, m_view_start;
    logic        m_last;
    logic        rx_stall_on = 1'b1;

    edit_scoreboard board = new();

    always #2 aclk = ~aclk;

    line_editor_with_history_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_key_symbol(s_key_symbol),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_line_char(m_line_char), .m_cursor_pos(m_cursor_pos),
        .m_line_length(m_line_length), .m_view_start(m_view_start),
        .m_last(m_last)
    );

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random ready while stalls are on, check on each accepted beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_beat({m_kind, m_line_char, m_cursor_pos, m_line_length,
                              m_view_start, m_last});
    end

    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready <= 1'b1;
            if (rx_stall_on) begin
                g = gap_len();
                if (g > 0) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                    repeat (g - 1) @(negedge aclk);
                end
            end
        end
    end

    // Send one key beat, with a random gap ahead of it; valid stays up until
    // the next key or an explicit stop
    task automatic send_key(logic [15:0] k);
        int g = gap_len();
        @(negedge aclk);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_key_symbol <= k;
        do @(posedge aclk); while (!s_ready);
        board.note_key(k);
    endtask

    // Drop valid after the last key of a run
    task automatic stop_keys();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain_and_config(logic [5:0] w);
        stop_keys();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.view_w = w;
    endtask

    function automatic logic [15:0] pick_char();
        return 16'($urandom_range(32, 127));
    endfunction

    function automatic logic [15:0] pick_key();
        int r = $urandom_range(0, 99);
        if (r < 50) return pick_char();
        case ($urandom_range(0, 11))
            0: return led_pkg::KEY_BACKSPACE;
            1: return led_pkg::KEY_DELETE;
            2: return led_pkg::KEY_LEFT;
            3: return led_pkg::KEY_RIGHT;
            4: return led_pkg::KEY_HOME;
            5: return led_pkg::KEY_END;
            6: return led_pkg::KEY_UP;
            7: return led_pkg::KEY_DOWN;
            8: return led_pkg::KEY_CLEAR;
            9: return led_pkg::KEY_ENTER;
            10: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 31));
        endcase
    endfunction

    logic [5:0] widths [5] = '{6'd1, 6'd63, 6'd4, 6'd0, 6'd17};

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: edges, every control key, full line, empty history
        send_key(led_pkg::KEY_UP);
        send_key(led_pkg::KEY_DOWN);
        send_key(led_pkg::KEY_ENTER);
        send_key(led_pkg::KEY_BACKSPACE);
        send_key(led_pkg::KEY_LEFT);
        send_key(led_pkg::KEY_DELETE);
        send_key(led_pkg::KEY_RIGHT);
        send_key(16'hFFFF);
        send_key(16'd31);
        send_key(led_pkg::PRINT_LO);
        send_key(led_pkg::PRINT_HI);
        send_key(16'd128);
        send_key(led_pkg::KEY_HOME);
        send_key(led_pkg::KEY_DELETE);
        send_key(led_pkg::KEY_END);
        send_key(led_pkg::KEY_LEFT);
        send_key(led_pkg::KEY_BACKSPACE);
        send_key(led_pkg::KEY_ENTER);
        for (int i = 0; i < MAX_LEN + 2; i++) send_key(pick_char());
        send_key(led_pkg::KEY_HOME);
        send_key(led_pkg::KEY_CLEAR);
        send_key(led_pkg::KEY_UP);
        send_key(led_pkg::KEY_DOWN);
        send_key(16'h5555);
        send_key(16'hAAAA);

        // Random editing phases under several view widths
        for (int p = 0; p < 6; p++) begin
            if (p > 0) drain_and_config(widths[p - 1]);
            rx_stall_on = (p != 2);
            for (int i = 0; i < 27; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 12)) send_key(pick_char());
                    send_key(led_pkg::KEY_ENTER);
                end else begin
                    send_key(pick_key());
                end
            end
        end

        stop_keys();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Covered %0d keys, %0d entered lines, %0d result beats checked.",
                 board.keys, board.lines, board.checked);
        $display("View widths 30, 1, 63, 4, 0 and 17 were exercised with history recall.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/led_pkg.sv
src/led_ram.sv
src/line_editor_with_history_unit.sv
src/led_chk.sv
sim/testbench.sv
